### sv/scfp_pkg.sv
// shared types and character codes for the serial command frame parser
package scfp_pkg;

  // byte position counter width, holds any frame capacity up to 127
  localparam int POS_W = 7;

  // character codes
  localparam logic [7:0] CH_DIR_BASE     = 8'h40;
  localparam logic [7:0] CH_DIR_LO       = 8'h41;
  localparam logic [7:0] CH_DIR_HI       = 8'h48;
  localparam logic [7:0] CH_DIRECT_LIMIT = 8'd10;
  localparam logic [7:0] CH_STOP         = 8'h5A;
  localparam logic [7:0] CH_OPEN         = 8'h7B;
  localparam logic [7:0] CH_CLOSE        = 8'h7D;
  localparam logic [7:0] CH_TAG_REPORT   = 8'h50;
  localparam logic [7:0] CH_TAG_SAVE     = 8'h57;
  localparam logic [7:0] CH_CMD_SKIP     = 8'h23;
  localparam logic [7:0] CH_CMD_VEL      = 8'h30;
  localparam logic [7:0] CH_CMD_KP       = 8'h31;
  localparam logic [7:0] CH_CMD_KI       = 8'h32;
  localparam logic [7:0] CH_DIGIT_ZERO   = 8'd48;

  // fixed positions inside a frame
  localparam logic [POS_W-1:0] POS_CMD = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TAG = POS_W'(3);

  // set target codes
  typedef logic [1:0] target_t;
  localparam target_t TGT_NONE = 2'd0;
  localparam target_t TGT_VEL  = 2'd1;
  localparam target_t TGT_KP   = 2'd2;
  localparam target_t TGT_KI   = 2'd3;

  // one result word
  typedef struct packed {
    logic [7:0]         echo_byte;
    logic [3:0]         direction;
    target_t            set_target;
    logic signed [31:0] set_value;
    logic               report_request;
    logic               save_request;
  } result_t;

endpackage

### sv/scfp_if.sv
// valid/ready channel interfaces for the input byte and the result word
interface scfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         echo_byte;
  logic [3:0]         direction;
  logic [1:0]         set_target;
  logic signed [31:0] set_value;
  logic               report_request;
  logic               save_request;

  modport source (output valid, output echo_byte, output direction, output set_target,
                  output set_value, output report_request, output save_request,
                  input ready);
  modport sink   (input valid, input echo_byte, input direction, input set_target,
                  input set_value, input report_request, input save_request,
                  output ready);
endinterface

### sv/serial_command_frame_parser_top.sv
// Serial command frame parser: takes one received byte per word on rx and returns one result
// word per byte on tx, echoing the byte with the current direction command and, when a '}'
// closes an open frame, the decoded set target and value or a report/save pulse. One byte is
// accepted every cycle when tx keeps up; each byte passes through the input register and then
// the result register, whose word is presented on tx, with the frame state updated as a byte
// moves from the input register into the result register. Bytes beyond FRAME_CAPACITY within
// a frame are dropped from counting and accumulation.
module serial_command_frame_parser_top import scfp_pkg::*; #(
  parameter int FRAME_CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  scfp_in_if.sink    rx,
  scfp_out_if.source tx
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_data;
  result_t    result;
  logic       advance;

  // input register moves on when the result register is free or draining
  assign advance  = in_valid && (!out_valid || tx.ready);
  assign rx.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // parse logic and frame state
  scfp_core #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || tx.ready) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign tx.valid          = out_valid;
  assign tx.echo_byte      = out_data.echo_byte;
  assign tx.direction      = out_data.direction;
  assign tx.set_target     = out_data.set_target;
  assign tx.set_value      = out_data.set_value;
  assign tx.report_request = out_data.report_request;
  assign tx.save_request   = out_data.save_request;

  // at most one frame action per result
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> $countones({tx.report_request, tx.save_request,
                             tx.set_target != TGT_NONE}) <= 1)
    else $error("more than one frame action in one result");

  // frame actions only come from a closing brace
  a_action_on_close: assert property (@(posedge clk) disable iff (rst)
    tx.valid && (tx.report_request || tx.save_request || tx.set_target != TGT_NONE)
      |-> tx.echo_byte == CH_CLOSE)
    else $error("frame action without closing brace");

  // value is zero unless a target is set
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.set_target == TGT_NONE |-> tx.set_value == 32'sd0)
    else $error("set value without target");

  // a held input word keeps its byte until it moves on
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input register lost a waiting byte");

endmodule

### sv/scfp_core.sv
// frame state registers and the per-byte parse logic
module scfp_core import scfp_pkg::*; #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  logic             frame_open, frame_open_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       command_char, command_char_next;
  logic [7:0]       tag_char, tag_char_next;
  logic [31:0]      number_accum, number_accum_next;
  logic [3:0]       direction_reg, direction_reg_next;

  logic        open_now;
  logic        counting;
  logic [31:0] digit;
  target_t     target;

  // direction command
  always_comb begin
    direction_reg_next = direction_reg;
    if (rx_byte >= CH_DIR_LO && rx_byte <= CH_DIR_HI) begin
      direction_reg_next = 4'(rx_byte - CH_DIR_BASE);
    end else if (rx_byte < CH_DIRECT_LIMIT) begin
      direction_reg_next = rx_byte[3:0];
    end else if (rx_byte == CH_STOP) begin
      direction_reg_next = 4'd0;
    end
  end

  // accumulate times ten plus digit, wrapping at 32 bits
  assign digit = {24'd0, rx_byte} - {24'd0, CH_DIGIT_ZERO};

  // command decode at frame close
  always_comb begin
    case (command_char)
      CH_CMD_VEL: target = TGT_VEL;
      CH_CMD_KP:  target = TGT_KP;
      CH_CMD_KI:  target = TGT_KI;
      default:    target = TGT_NONE;
    endcase
  end

  assign open_now = frame_open || (rx_byte == CH_OPEN);
  assign counting = open_now && (byte_position < POS_W'(FRAME_CAPACITY));

  // frame state update and result
  always_comb begin
    frame_open_next    = frame_open;
    byte_position_next = byte_position;
    command_char_next  = command_char;
    tag_char_next      = tag_char;
    number_accum_next  = number_accum;

    result.echo_byte      = rx_byte;
    result.direction      = direction_reg_next;
    result.set_target     = TGT_NONE;
    result.set_value      = '0;
    result.report_request = 1'b0;
    result.save_request   = 1'b0;

    if (rx_byte == CH_CLOSE) begin
      if (frame_open) begin
        if (tag_char == CH_TAG_REPORT) begin
          result.report_request = 1'b1;
        end else if (tag_char == CH_TAG_SAVE) begin
          result.save_request = 1'b1;
        end else if (command_char != CH_CMD_SKIP && target != TGT_NONE) begin
          result.set_target = target;
          result.set_value  = number_accum;
        end
      end
      frame_open_next    = 1'b0;
      byte_position_next = '0;
      command_char_next  = '0;
      tag_char_next      = '0;
      number_accum_next  = '0;
    end else begin
      frame_open_next = open_now;
      if (counting) begin
        if (byte_position == POS_CMD) begin
          command_char_next = rx_byte;
        end
        if (byte_position == POS_TAG) begin
          tag_char_next = rx_byte;
        end
        if (byte_position >= POS_TAG) begin
          number_accum_next = (number_accum << 3) + (number_accum << 1) + digit;
        end
        byte_position_next = byte_position + POS_W'(1);
      end
    end
  end

  // state registers, advanced once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open    <= 1'b0;
      byte_position <= '0;
      command_char  <= '0;
      tag_char      <= '0;
      number_accum  <= '0;
      direction_reg <= '0;
    end else if (step) begin
      frame_open    <= frame_open_next;
      byte_position <= byte_position_next;
      command_char  <= command_char_next;
      tag_char      <= tag_char_next;
      number_accum  <= number_accum_next;
      direction_reg <= direction_reg_next;
    end
  end

endmodule

### sim/scfp_result_check.sv
// result checker for the serial command frame parser: predicts every result word and compares
module scfp_result_check import scfp_pkg::*; #(
  parameter int FRAME_CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  scfp_in_if   rx,
  scfp_out_if  tx,
  output int   mismatches,
  output int   outstanding,
  output int   words_checked,
  output int   value_sets,
  output int   reports,
  output int   saves
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted parser state
  logic             frame_open_q;
  logic [POS_W-1:0] pos_q;
  logic [7:0]       cmd_q;
  logic [7:0]       tag_q;
  logic [31:0]      acc_q;
  logic [3:0]       dir_q;

  // predicted result words, oldest first
  result_t expected_words [$];

  // advance the predicted state by one byte and build its result word
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    if (b >= CH_DIR_LO && b <= CH_DIR_HI) begin
      dir_q = 4'(b - CH_DIR_BASE);
    end else if (b < CH_DIRECT_LIMIT) begin
      dir_q = b[3:0];
    end else if (b == CH_STOP) begin
      dir_q = 4'd0;
    end
    if (b == CH_CLOSE) begin
      // judge the frame only if one is open, then clear it in any case
      if (frame_open_q) begin
        if (tag_q == CH_TAG_REPORT) begin
          r.report_request = 1'b1;
        end else if (tag_q == CH_TAG_SAVE) begin
          r.save_request = 1'b1;
        end else if (cmd_q != CH_CMD_SKIP) begin
          case (cmd_q)
            CH_CMD_VEL: r.set_target = TGT_VEL;
            CH_CMD_KP:  r.set_target = TGT_KP;
            CH_CMD_KI:  r.set_target = TGT_KI;
            default:    r.set_target = TGT_NONE;
          endcase
          if (r.set_target != TGT_NONE) r.set_value = acc_q;
        end
      end
      frame_open_q = 1'b0;
      pos_q        = '0;
      cmd_q        = '0;
      tag_q        = '0;
      acc_q        = '0;
    end else begin
      if (b == CH_OPEN) frame_open_q = 1'b1;
      // bytes past capacity are neither counted nor accumulated
      if (frame_open_q && pos_q < FRAME_CAPACITY) begin
        if (pos_q == POS_CMD) cmd_q = b;
        if (pos_q == POS_TAG) tag_q = b;
        if (pos_q >= POS_TAG) acc_q = acc_q * 32'd10 + ({24'd0, b} - 32'd48);
        pos_q = pos_q + 1'b1;
      end
    end
    r.echo_byte = b;
    r.direction = dir_q;
    return r;
  endfunction

  // report one field that differs from its prediction
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      frame_open_q = 1'b0;
      pos_q        = '0;
      cmd_q        = '0;
      tag_q        = '0;
      acc_q        = '0;
      dir_q        = '0;
      expected_words.delete();
      mismatches    = 0;
      words_checked = 0;
      value_sets    = 0;
      reports       = 0;
      saves         = 0;
    end else begin
      if (rx.valid && rx.ready) expected_words.push_back(decode_byte(rx.rx_byte));
      if (tx.valid && tx.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: no result word expected, actual echo %0h", $time, tx.echo_byte);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("echo_byte", 32'(want.echo_byte), 32'(tx.echo_byte));
          check_field("direction", 32'(want.direction), 32'(tx.direction));
          check_field("set_target", 32'(want.set_target), 32'(tx.set_target));
          check_field("set_value", want.set_value, tx.set_value);
          check_field("report_request", 32'(want.report_request), 32'(tx.report_request));
          check_field("save_request", 32'(want.save_request), 32'(tx.save_request));
          words_checked++;
          if (want.set_target != TGT_NONE) value_sets++;
          if (want.report_request) reports++;
          if (want.save_request) saves++;
        end
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

### sim/testbench.sv
// top of the serial command frame parser testbench: clock, reset, byte stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scfp_pkg::*;

  localparam int FRAME_CAPACITY = 64;
  localparam int TOTAL_BYTES    = 1025;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 500000;
  localparam logic [7:0] SEP    = 8'h2C;
  localparam logic [7:0] MINUS  = 8'h2D;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scfp_in_if  rx_if ();
  scfp_out_if tx_if ();

  int mismatches;
  int outstanding;
  int words_checked;
  int value_sets;
  int reports;
  int saves;
  int bytes_sent  = 0;
  int cycle_count = 0;
  bit calm        = 1'b1;
  bit hold_req    = 1'b0;
  bit holding     = 1'b0;

  // short frames, every close outcome and the direction extremes
  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'hFF, CH_DIR_LO, CH_DIR_HI, 8'h09, CH_STOP, CH_CLOSE,
    CH_OPEN, CH_CLOSE,
    CH_OPEN, CH_CMD_KP, CH_CLOSE,
    CH_OPEN, CH_CMD_VEL, SEP, CH_DIGIT_ZERO + 8'd5, CH_CLOSE,
    CH_OPEN, CH_CMD_KI, SEP, CH_TAG_REPORT, CH_CLOSE,
    CH_OPEN, CH_CMD_SKIP, SEP, CH_TAG_SAVE, CH_CLOSE
  };

  serial_command_frame_parser_top #(.FRAME_CAPACITY(FRAME_CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  scfp_result_check #(.FRAME_CAPACITY(FRAME_CAPACITY)) result_check (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx_if),
    .tx            (tx_if),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .value_sets    (value_sets),
    .reports       (reports),
    .saves         (saves)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || holding) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // any byte except the frame close
  function automatic logic [7:0] any_but_close();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_CLOSE) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] digit();
    return CH_DIGIT_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // offer one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // build one random sequence: a frame, a broken frame, or loose bytes
  task automatic send_sequence();
    logic [7:0] seq [$];
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      // well-formed frame, overlong now and then
      seq.push_back(CH_OPEN);
      case ($urandom_range(0, 5))
        0:       seq.push_back(CH_CMD_VEL);
        1:       seq.push_back(CH_CMD_KP);
        2:       seq.push_back(CH_CMD_KI);
        3:       seq.push_back(CH_CMD_SKIP);
        4:       seq.push_back(any_but_close());
        default: seq.push_back(CH_CMD_VEL);
      endcase
      seq.push_back(SEP);
      case ($urandom_range(0, 6))
        0:       seq.push_back(CH_TAG_REPORT);
        1:       seq.push_back(CH_TAG_SAVE);
        6:       seq.push_back(MINUS);
        default: seq.push_back(digit());
      endcase
      n = (kind < 5) ? $urandom_range(60, 75) : $urandom_range(0, 12);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) seq.push_back(any_but_close());
        else seq.push_back(digit());
      end
      seq.push_back(CH_CLOSE);
    end else if (kind < 82) begin
      // broken frame with nested opens, random bytes, maybe no close
      seq.push_back(CH_OPEN);
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0) seq.push_back(CH_OPEN);
        else seq.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1)) seq.push_back(CH_CLOSE);
    end else if (kind < 95) begin
      // loose bytes, direction commands among them
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0:       seq.push_back(CH_DIR_LO + 8'($urandom_range(0, 7)));
          1:       seq.push_back(8'($urandom_range(0, 9)));
          2:       seq.push_back(CH_STOP);
          default: seq.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      seq.push_back(CH_CLOSE);
    end
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    tx_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        tx_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
      end else if (calm) begin
        tx_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        tx_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        tx_if.ready <= 1'b0;
        repeat (idle_gap() + 1) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int next_mode_at;
    bit hold_done;
    next_mode_at = 0;
    hold_done    = 1'b0;
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed bytes with no idling
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    // random sequences, idling mode picked every few dozen bytes
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= next_mode_at) begin
        calm = ($urandom_range(0, 3) == 0);
        next_mode_at = bytes_sent + 40;
      end
      if (!hold_done && bytes_sent >= TOTAL_BYTES / 2) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      send_sequence();
    end
    rx_if.valid <= 1'b0;

    // drain, once the count includes the last byte
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, checked %0d result words", bytes_sent, words_checked);
    $display("Frame closes seen: %0d value sets, %0d report and %0d save requests",
             value_sets, reports, saves);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      if (outstanding != 0) $display("%0t: %0d result words never arrived", $time, outstanding);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
